@@ src/tsi_pkg.sv @@
package tsi_pkg;

  localparam int MAX_DIVISIONS = 64;
  localparam int NUM_SLOTS     = 6;
  localparam int NUM_CORNERS   = 8;
  localparam int TET_VERTS     = 4;
  localparam int VERT_W        = 18;

  typedef logic [VERT_W-1:0] vert_t;
  typedef logic [5:0]        coord_t;
  typedef logic [2:0]        slot_t;
  typedef logic [2:0]        corner_t;

  localparam slot_t LAST_SLOT = 3'd5;

  // inverse of 3 modulo 2^18, for exact division of a known multiple of 3
  localparam vert_t INV3 = 18'h2AAAB;

  typedef enum logic [0:0] {
    REG_DIVISION_COUNT = 1'b0,
    REG_BASE_OFFSET    = 1'b1
  } cfg_reg_t;

  // six-tetrahedron split of the cube, corner c at (i + c[0], j + c[1], k + c[2])
  localparam corner_t SPLIT_TABLE [NUM_SLOTS][TET_VERTS] = '{
    '{3'd0, 3'd1, 3'd2, 3'd4},
    '{3'd1, 3'd2, 3'd4, 3'd3},
    '{3'd1, 3'd3, 3'd4, 3'd5},
    '{3'd3, 3'd4, 3'd5, 3'd6},
    '{3'd2, 3'd3, 3'd6, 3'd4},
    '{3'd3, 3'd5, 3'd7, 3'd6}
  };

  typedef struct packed {
    vert_t [TET_VERTS-1:0] vert;
    logic                  kept;
  } tet_row_t;

endpackage

@@ src/tsi_ifs.sv @@
interface tsi_cube_if import tsi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t cube_i;
  coord_t cube_j;
  coord_t cube_k;

  modport source (output valid, output cube_i, output cube_j, output cube_k, input ready);
  modport sink   (input valid, input cube_i, input cube_j, input cube_k, output ready);
endinterface

interface tsi_tet_if import tsi_pkg::*; ();
  logic  valid;
  logic  ready;
  vert_t vertex_a;
  vert_t vertex_b;
  vert_t vertex_c;
  vert_t vertex_d;
  logic  kept;
  slot_t tet_slot;
  logic  last;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output vertex_d, output kept, output tet_slot, output last, input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input vertex_d, input kept, input tet_slot, input last, output ready);
endinterface

interface tsi_cfg_if import tsi_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_reg_t index;
  vert_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tetrahedron_subdivision_indices_top.sv @@
// The first result word of a cube passes the arithmetic pipeline, the unload buffer and the output register.
// Throughput: the six result words of a cube leave one per cycle while tet.ready is high,
// so the output channel sets the cube rate.
// A five-stage arithmetic pipeline feeds a six-row unload buffer and an output register.
// Reset (synchronous, active high) empties the pipeline and sets division_count to 1,
// base_offset to 0.
module tetrahedron_subdivision_indices_top import tsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  tsi_cube_if.sink  cube,
  tsi_tet_if.source tet,
  tsi_cfg_if.sink   cfg
);

  // configuration
  logic [6:0] division_count;
  vert_t      base_offset;
  logic [6:0] n_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      division_count <= 7'd1;
      base_offset    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIVISION_COUNT: division_count <= cfg.data[6:0];
        REG_BASE_OFFSET:    base_offset    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign n_eff = (division_count > 7'(MAX_DIVISIONS)) ? 7'(MAX_DIVISIONS) : division_count;

  // pipeline control: all stages move together
  logic pipe_en;
  logic buf_take;
  logic v1, v2, v3, v4, v5;

  assign pipe_en    = !v5 || buf_take;
  assign cube.ready = pipe_en;

  // stage 1: corner sums and inside tests
  logic [7:0] s1 [NUM_CORNERS];
  logic [7:0] u1 [NUM_CORNERS];
  logic [6:0] d1 [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] in1;
  logic ok1;

  logic [7:0] s1_next [NUM_CORNERS];
  logic [7:0] u1_next [NUM_CORNERS];
  logic [6:0] d1_next [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] in1_next;
  logic ok1_next;

  always_comb begin
    logic [6:0] a, b, d;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      a = {1'b0, cube.cube_i} + 7'(c & 1);
      b = {1'b0, cube.cube_j} + 7'((c >> 1) & 1);
      d = {1'b0, cube.cube_k} + 7'((c >> 2) & 1);
      s1_next[c]  = 8'(a) + 8'(b) + 8'(d);
      u1_next[c]  = 8'(b) + 8'(d);
      d1_next[c]  = d;
      in1_next[c] = (s1_next[c] <= {1'b0, n_eff});
    end
    ok1_next = ({1'b0, cube.cube_i} < n_eff) && ({1'b0, cube.cube_j} < n_eff) &&
               ({1'b0, cube.cube_k} < n_eff);
  end

  // stage 2: s(s+1), triangular number, slot keep flags
  logic [15:0] m2  [NUM_CORNERS];
  logic [7:0]  sp2 [NUM_CORNERS];
  logic [13:0] t2  [NUM_CORNERS];
  logic [6:0]  d2  [NUM_CORNERS];
  logic [NUM_SLOTS-1:0] keep2;
  logic [NUM_SLOTS-1:0] keep2_next;

  always_comb begin
    for (int t = 0; t < NUM_SLOTS; t++) begin
      keep2_next[t] = ok1;
      for (int x = 0; x < TET_VERTS; x++)
        keep2_next[t] = keep2_next[t] && in1[SPLIT_TABLE[t][x]];
    end
  end

  // stage 3: s(s+1)(s+2)/2, low bits only
  vert_t       h3 [NUM_CORNERS];
  logic [13:0] w3 [NUM_CORNERS];
  logic [NUM_SLOTS-1:0] keep3;

  // stage 4: exact divide by 3 gives the tetrahedral number mod 2^18
  vert_t       t4 [NUM_CORNERS];
  logic [13:0] w4 [NUM_CORNERS];
  logic [NUM_SLOTS-1:0] keep4;

  // stage 5: full vertex numbers
  vert_t num5 [NUM_CORNERS];
  logic [NUM_SLOTS-1:0] keep5;

  always_ff @(posedge clk) begin
    logic [23:0] p;
    logic [35:0] q;
    logic [15:0] uu;
    if (pipe_en) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
        s1[c] <= s1_next[c];
        u1[c] <= u1_next[c];
        d1[c] <= d1_next[c];

        m2[c]  <= 16'(s1[c]) * 16'(s1[c] + 8'd1);
        sp2[c] <= s1[c] + 8'd2;
        uu      = 16'(u1[c]) * 16'(u1[c] + 8'd1);
        t2[c]  <= uu[14:1];
        d2[c]  <= d1[c];

        p      = 24'(m2[c]) * 24'(sp2[c]);
        h3[c] <= p[18:1];
        w3[c] <= t2[c] + 14'(d2[c]);

        q      = 36'(h3[c]) * 36'(INV3);
        t4[c] <= q[VERT_W-1:0];
        w4[c] <= w3[c];

        num5[c] <= t4[c] + vert_t'(w4[c]) + base_offset;
      end
      in1   <= in1_next;
      ok1   <= ok1_next;
      keep2 <= keep2_next;
      keep3 <= keep2;
      keep4 <= keep3;
      keep5 <= keep4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (pipe_en) begin
      v1 <= cube.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // unload buffer: one row per slot, shifted toward row 0 as words leave
  tet_row_t rows [NUM_SLOTS];
  logic     bvalid;
  slot_t    slot;
  logic     issue;
  logic     buf_done;

  assign issue    = bvalid && (!tet.valid || tet.ready);
  assign buf_done = issue && (slot == LAST_SLOT);
  assign buf_take = !bvalid || buf_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      slot   <= '0;
    end else if (buf_take) begin
      bvalid <= v5;
      slot   <= '0;
    end else if (issue) begin
      slot <= slot + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take && v5) begin
      for (int t = 0; t < NUM_SLOTS; t++) begin
        rows[t].kept <= keep5[t];
        for (int x = 0; x < TET_VERTS; x++)
          rows[t].vert[x] <= keep5[t] ? num5[SPLIT_TABLE[t][x]] : '0;
      end
    end else if (issue) begin
      for (int t = 0; t < NUM_SLOTS - 1; t++)
        rows[t] <= rows[t+1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tet.valid <= 1'b0;
    end else if (issue) begin
      tet.valid <= 1'b1;
    end else if (tet.ready) begin
      tet.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tet.vertex_a <= rows[0].vert[0];
      tet.vertex_b <= rows[0].vert[1];
      tet.vertex_c <= rows[0].vert[2];
      tet.vertex_d <= rows[0].vert[3];
      tet.kept     <= rows[0].kept;
      tet.tet_slot <= slot;
      tet.last     <= (slot == LAST_SLOT);
    end
  end

`ifndef SYNTH
  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    tet.valid && tet.ready && !tet.last |=>
      tet.valid && (tet.tet_slot == $past(tet.tet_slot) + 3'd1))
    else $error("slot did not advance after a non-final word");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    tet.valid |-> (tet.last == (tet.tet_slot == LAST_SLOT)))
    else $error("last flag out of step with slot");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    tet.valid && !tet.kept |->
      (tet.vertex_a == '0) && (tet.vertex_b == '0) &&
      (tet.vertex_c == '0) && (tet.vertex_d == '0))
    else $error("dropped tetrahedron carries vertex numbers");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v5 && !buf_take |=> v5 && (num5[0] == $past(num5[0])))
    else $error("pipeline tail changed while stalled");
`endif

endmodule
